// ----- rtl/chc_pkg.sv -----
// ----------------------------------------------------------------------------
// chc_pkg
// Shared constants, codes and types of the canonical Huffman encoder.
// ----------------------------------------------------------------------------
package chc_pkg;

    localparam int ALPHABET_SIZE = 512;
    localparam int MAX_CODE_LEN  = 32;

    localparam int SYM_W     = 9;
    localparam int LEN_W     = 6;
    localparam int CODE_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int ADDR_W    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int SYM_EXT_W = (ADDR_W + 1 > SYM_W) ? ADDR_W + 1 : SYM_W;
    localparam int RUN_W     = MAX_CODE_LEN;
    localparam int EP_W      = 8;

    localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNSORTED   = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW   = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNASSIGNED = 2'd3;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [EP_W-1:0]   t_epoch;

    // one code table entry; the epoch tag stands in for the assigned mark
    typedef struct packed {
        t_epoch             epoch;
        t_len               len;
        logic [CODE_W-1:0]  word;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // control from the pipeline into the code generator
    typedef struct packed {
        logic commit;
        logic clear;
        t_len len;
    } t_gen_ctl;

    // generator verdict for the item in flight
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [RUN_W-1:0]  word;
    } t_gen_res;

endpackage

// ----- rtl/chc_code_ram.sv -----
// ----------------------------------------------------------------------------
// chc_code_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chc_code_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 46
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/chc_code_gen.sv -----
// ----------------------------------------------------------------------------
// chc_code_gen
// Running canonical code and length, with the next-code check and step.
// ----------------------------------------------------------------------------
module chc_code_gen (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chc_pkg::t_gen_ctl i_ctl,
    output chc_pkg::t_gen_res o_res
);
    import chc_pkg::*;

    localparam logic [RUN_W-1:0] RUN_ONES = {RUN_W{1'b1}};

    logic [RUN_W-1:0] r_run_code, n_run_code;
    t_len             r_run_len,  n_run_len;

    logic [RUN_W-1:0] ones_mask;
    logic [RUN_W-1:0] code_inc;
    logic [RUN_W-1:0] next_word;
    logic [LEN_W:0]   len_ext;

    always_comb begin
        len_ext   = {1'b0, i_ctl.len};
        ones_mask = RUN_ONES >> ((LEN_W+1)'(MAX_CODE_LEN) - {1'b0, r_run_len});
        code_inc  = r_run_code + RUN_W'(1);
        next_word = code_inc << (i_ctl.len - r_run_len);
    end

    always_comb begin
        o_res.status = ST_OK;
        o_res.word   = '0;
        if (i_ctl.len == '0) begin
            o_res.status = ST_UNSORTED;
        end else if (len_ext > (LEN_W+1)'(MAX_CODE_LEN)) begin
            o_res.status = ST_OVERFLOW;
        end else if (r_run_len == '0) begin
            o_res.word = '0;
        end else if (i_ctl.len < r_run_len) begin
            o_res.status = ST_UNSORTED;
        end else if (r_run_code == ones_mask) begin
            o_res.status = ST_OVERFLOW;
        end else begin
            o_res.word = next_word;
        end
    end

    always_comb begin
        n_run_code = r_run_code;
        n_run_len  = r_run_len;
        if (i_ctl.clear) begin
            n_run_code = '0;
            n_run_len  = '0;
        end else if (i_ctl.commit && (o_res.status == ST_OK)) begin
            n_run_code = o_res.word;
            n_run_len  = i_ctl.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_code <= '0;
            r_run_len  <= '0;
        end else begin
            r_run_code <= n_run_code;
            r_run_len  <= n_run_len;
        end
    end

endmodule

// ----- rtl/canonical_huffman_encoder.sv -----
// Path: an accepted request is registered in stage 1, and its result then in the output registers.
// Throughput: one request per cycle while neither the output stall nor the sweep holds stage 1;
// the read of the code table is registered, with write-to-read forwarding, as is the running code.
// Reset: a sweep over all 512 entries tags every table entry unassigned, stall high.
// Every 255th start request triggers the same sweep, and the request
// behind it waits in stage 1 until the sweep ends; other starts only open a new epoch.
// ----------------------------------------------------------------------------
// canonical_huffman_encoder
// Canonical Huffman code assignment and symbol lookup over one code table.
// ----------------------------------------------------------------------------
module canonical_huffman_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [chc_pkg::CMD_W-1:0]     i_cmd,
    input  logic [chc_pkg::SYM_W-1:0]     i_symbol,
    input  logic [chc_pkg::LEN_W-1:0]     i_code_length,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [chc_pkg::CMD_W-1:0]     o_kind,
    output logic [chc_pkg::CODE_W-1:0]    o_code_bits,
    output logic [chc_pkg::LEN_W-1:0]     o_bit_count,
    output logic [chc_pkg::STAT_W-1:0]    o_status
);
    import chc_pkg::*;

    localparam t_epoch EPOCH_LAST  = {EP_W{1'b1}};
    localparam t_epoch EPOCH_FIRST = t_epoch'(1);
    localparam t_addr  ADDR_LAST   = ADDR_W'(ALPHABET_SIZE - 1);

    // stage 1 registers
    logic              r_s1_vld, n_s1_vld;
    logic [CMD_W-1:0]  r_s1_cmd;
    logic [SYM_W-1:0]  r_s1_sym;
    t_len              r_s1_len;

    // output registers
    logic              r_out_vld, n_out_vld;
    logic [CMD_W-1:0]  r_kind,  n_kind;
    logic [CODE_W-1:0] r_bits,  n_bits;
    t_len              r_count, n_count;
    logic [STAT_W-1:0] r_stat,  n_stat;

    // table sweep and epoch
    logic              r_clr_busy, n_clr_busy;
    t_addr             r_clr_addr, n_clr_addr;
    t_epoch            r_epoch,    n_epoch;

    // forwarding of a write that collides with the read issued alongside it
    logic              r_fwd_hit;
    t_entry            r_fwd_data;

    logic              in_accept;
    logic              s1_adv;
    logic              s1_hold;
    logic              s1_in_range;
    t_addr             s1_addr;
    t_addr             in_addr;
    t_addr             rd_addr;
    logic [SYM_EXT_W-1:0] in_sym_ext;
    logic [SYM_EXT_W-1:0] s1_sym_ext;
    t_entry            rd_entry;
    t_entry            ent;
    logic              mem_we;
    t_addr             mem_waddr;
    t_entry            mem_wdata;
    logic              asg_fire;
    logic              start_fire;
    t_gen_ctl          gen_ctl;
    t_gen_res          gen_res;

    always_comb begin
        in_sym_ext  = SYM_EXT_W'(i_symbol);
        s1_sym_ext  = SYM_EXT_W'(r_s1_sym);
        in_addr     = in_sym_ext[ADDR_W-1:0];
        s1_addr     = s1_sym_ext[ADDR_W-1:0];
        s1_in_range = s1_sym_ext < SYM_EXT_W'(ALPHABET_SIZE);
    end

    // hold stage 1 while the sweep owns the table or a stalled result blocks the output
    assign s1_adv     = r_s1_vld && !r_clr_busy && (!r_out_vld || !i_out_stall);
    assign s1_hold    = r_s1_vld && !s1_adv;
    assign o_in_stall = r_clr_busy || s1_hold;
    assign in_accept  = i_in_valid && !o_in_stall;

    // re-read the held symbol so its data stays current while stalled
    assign rd_addr    = s1_hold ? s1_addr : in_addr;
    assign ent        = r_fwd_hit ? r_fwd_data : rd_entry;

    assign asg_fire   = s1_adv && (r_s1_cmd == CMD_ASSIGN) && s1_in_range;
    assign start_fire = s1_adv && (r_s1_cmd == CMD_START);

    always_comb begin
        gen_ctl.commit = asg_fire;
        gen_ctl.clear  = start_fire;
        gen_ctl.len    = r_s1_len;
    end

    chc_code_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (gen_ctl),
        .o_res   (gen_res)
    );

    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we          = asg_fire && (gen_res.status == ST_OK);
            mem_waddr       = s1_addr;
            mem_wdata.epoch = r_epoch;
            mem_wdata.len   = r_s1_len;
            mem_wdata.word  = CODE_W'(gen_res.word);
        end
    end

    chc_code_ram #(
        .DEPTH (ALPHABET_SIZE),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        r_fwd_hit  <= mem_we && (mem_waddr == rd_addr);
        r_fwd_data <= mem_wdata;
    end

    // result of the item in stage 1
    always_comb begin
        n_kind  = r_s1_cmd;
        n_bits  = '0;
        n_count = '0;
        n_stat  = ST_OK;
        case (r_s1_cmd)
            CMD_ASSIGN: begin
                if (!s1_in_range) begin
                    n_stat = ST_UNASSIGNED;
                end else if (gen_res.status != ST_OK) begin
                    n_stat = gen_res.status;
                end else begin
                    n_bits  = CODE_W'(gen_res.word);
                    n_count = r_s1_len;
                end
            end
            CMD_ENCODE: begin
                if (!s1_in_range || (ent.epoch != r_epoch)) begin
                    n_stat = ST_UNASSIGNED;
                end else begin
                    n_bits  = ent.word;
                    n_count = ent.len;
                end
            end
            default: begin
                n_stat = ST_OK;
            end
        endcase
    end

    always_comb begin
        if (s1_adv) begin
            n_out_vld = 1'b1;
        end else if (i_out_stall) begin
            n_out_vld = r_out_vld;
        end else begin
            n_out_vld = 1'b0;
        end

        if (in_accept) begin
            n_s1_vld = 1'b1;
        end else if (s1_adv) begin
            n_s1_vld = 1'b0;
        end else begin
            n_s1_vld = r_s1_vld;
        end
    end

    // advance the sweep, or open a new epoch on a start request
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        n_epoch    = r_epoch;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + t_addr'(1);
            if (r_clr_addr == ADDR_LAST) begin
                n_clr_busy = 1'b0;
            end
        end else if (start_fire) begin
            if (r_epoch == EPOCH_LAST) begin
                n_epoch    = EPOCH_FIRST;
                n_clr_busy = 1'b1;
                n_clr_addr = '0;
            end else begin
                n_epoch = r_epoch + t_epoch'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_epoch    <= EPOCH_FIRST;
        end else begin
            r_s1_vld   <= n_s1_vld;
            r_out_vld  <= n_out_vld;
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
            r_epoch    <= n_epoch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd <= i_cmd;
            r_s1_sym <= i_symbol;
            r_s1_len <= i_code_length;
        end
        if (s1_adv) begin
            r_kind  <= n_kind;
            r_bits  <= n_bits;
            r_count <= n_count;
            r_stat  <= n_stat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_kind      = r_kind;
    assign o_code_bits = r_bits;
    assign o_bit_count = r_count;
    assign o_status    = r_stat;

endmodule

// ----- rtl/chc_checker.sv -----
// ----------------------------------------------------------------------------
// chc_checker
// Port-level checks of the canonical Huffman encoder, bound to the top level.
// ----------------------------------------------------------------------------
module chc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [chc_pkg::CMD_W-1:0]     i_cmd,
    input logic [chc_pkg::SYM_W-1:0]     i_symbol,
    input logic [chc_pkg::LEN_W-1:0]     i_code_length,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [chc_pkg::CMD_W-1:0]     o_kind,
    input logic [chc_pkg::CODE_W-1:0]    o_code_bits,
    input logic [chc_pkg::LEN_W-1:0]     o_bit_count,
    input logic [chc_pkg::STAT_W-1:0]    o_status
);
    import chc_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_kind) && $stable(o_code_bits)
            && $stable(o_bit_count) && $stable(o_status))
        else $error("stalled result changed");

    // table sweep blocks requests right after reset
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request port open during table sweep");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |->
            (o_code_bits == '0) && (o_bit_count == '0))
        else $error("error result carries code bits");

    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_kind == CMD_START) || (o_kind == CMD_RSVD)) |->
            (o_code_bits == '0) && (o_bit_count == '0) && (o_status == ST_OK))
        else $error("start result not clean");

    a_code_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_OK)
        && ((o_kind == CMD_ASSIGN) || (o_kind == CMD_ENCODE)) |->
            (o_bit_count != '0)
            && ({1'b0, o_bit_count} <= (LEN_W+1)'(MAX_CODE_LEN)))
        else $error("code length out of range");

endmodule

bind canonical_huffman_encoder chc_checker u_chc_checker (.*);
